[hw/rtl/flash_config_log_store_defines.svh]
// assertion helpers for the checker file
`ifndef FLASH_CONFIG_LOG_STORE_DEFINES_SVH
`define FLASH_CONFIG_LOG_STORE_DEFINES_SVH

// property sampled on the block clock, off while reset is high
`define FCLS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition that must hold in the cycle after a trigger
`define FCLS_ASSERT_NEXT(label, trig, cond, msg) \
   `FCLS_ASSERT(label, trig |=> cond, msg)

`endif

[hw/rtl/fcls_pkg.sv]
`default_nettype none

package fcls_pkg;

   // sizes
   localparam int NUM_SETTINGS     = 4;
   localparam int LOG_SLOTS        = 256;
   localparam int NUM_DEFAULT_REGS = 4;
   localparam int VALUE_W          = 16;
   localparam int IDX_W            = 4;
   localparam int CMD_W            = 2;
   localparam int SLOTS_W          = 9;
   localparam int CSR_IDX_W        = 8;

   localparam int ADDR_W    = $clog2(LOG_SLOTS);
   localparam int PTR_W     = $clog2(LOG_SLOTS + 1);
   localparam int SH_W      = (NUM_SETTINGS > 1) ? $clog2(NUM_SETTINGS) : 1;
   localparam int DFLT_W    = $clog2(NUM_DEFAULT_REGS);
   localparam int LAST_FILL = NUM_SETTINGS - 1;

   // compare constants
   localparam logic [IDX_W:0]     SETTINGS_LIMIT = NUM_SETTINGS[IDX_W:0];
   localparam logic [PTR_W-1:0]   PTR_FULL       = LOG_SLOTS[PTR_W-1:0];
   localparam logic [PTR_W-1:0]   PTR_LAST_FILL  = LAST_FILL[PTR_W-1:0];
   localparam logic [CSR_IDX_W-1:0] CSR_REGS     = NUM_DEFAULT_REGS[CSR_IDX_W-1:0];

   typedef logic [VALUE_W-1:0] value_type;

   localparam value_type RESET_DEFAULTS [NUM_DEFAULT_REGS] = '{
      16'd1, 16'd50, 16'd40, 16'd70
   };

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_SAVE = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_COMPACTED = 2'd1,
      STS_DEFAULTS  = 2'd2,
      STS_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_REPLAY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [IDX_W-1:0]   setting_id;
      logic [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] read_value;
      logic [SLOTS_W-1:0] slots_used;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [VALUE_W-1:0] value;
   } log_entry_type;

   // reset value of one setting, zero past the default registers
   function automatic value_type reset_default(input int k);
      value_type result;
      result = '0;
      if (k < NUM_DEFAULT_REGS) begin
         result = RESET_DEFAULTS[k[DFLT_W-1:0]];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/flash_config_log_store.sv]
`default_nettype none

// channel   direction  ports                                   payload
// req       in         req_valid / req_ready                   fcls_pkg::req_type
// rsp       out        rsp_valid / rsp_ready                   fcls_pkg::rsp_type
// csr       in         csr_valid / csr_ready, csr_index        default value (16 bits)
//
// one item at a time; read and save go from the transfer straight to the done state,
// a load of a blank page and a compaction pass through the fill state first, a replay
// through the replay state, the single log page memory port doing one slot per cycle.
// the slot count stands for the erased state, so reset needs no memory clearing pass.
// a waiting result sits in the output register; the next item is taken meanwhile.
// synchronous active-high reset; csr writes are always taken.

module flash_config_log_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  fcls_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output fcls_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcls_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fcls_pkg::VALUE_W-1:0]     csr_data
);

   fcls_pkg::value_type dflt_ff [fcls_pkg::NUM_DEFAULT_REGS];
   fcls_pkg::value_type dflt [fcls_pkg::NUM_SETTINGS];
   logic                res_valid;
   logic                res_ready;
   fcls_pkg::rsp_type   res_data;
   logic                rsp_valid_ff, rsp_valid_in;
   fcls_pkg::rsp_type   rsp_data_ff;

   // default registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= fcls_pkg::RESET_DEFAULTS;
      end else if (csr_valid && (csr_index < fcls_pkg::CSR_REGS)) begin
         dflt_ff[csr_index[fcls_pkg::DFLT_W-1:0]] <= csr_data;
      end
   end

   // settings past the default registers default to zero
   for (genvar k = 0; k < fcls_pkg::NUM_SETTINGS; k++) begin : g_dflt
      if (k < fcls_pkg::NUM_DEFAULT_REGS) begin : g_reg
         assign dflt[k] = dflt_ff[k];
      end else begin : g_zero
         assign dflt[k] = '0;
      end
   end

   fcls_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .dflt      (dflt),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/fcls_log_ram.sv]
`default_nettype none

module fcls_log_ram #(
   parameter int  DEPTH = 256,
   parameter int  WIDTH = 20,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/fcls_engine.sv]
`default_nettype none

module fcls_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fcls_pkg::req_type   req_data,
   input  fcls_pkg::value_type dflt [fcls_pkg::NUM_SETTINGS],
   output logic                res_valid,
   input  logic                res_ready,
   output fcls_pkg::rsp_type   res_data
);

   fcls_pkg::state_type  state_ff, state_in;
   fcls_pkg::status_type status_ff, status_in;
   logic [fcls_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [fcls_pkg::PTR_W-1:0] free_ff, free_in;
   logic [fcls_pkg::PTR_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   fcls_pkg::value_type        shadow_ff [fcls_pkg::NUM_SETTINGS];
   fcls_pkg::value_type        shadow_in [fcls_pkg::NUM_SETTINGS];

   logic                        wr_en;
   logic [fcls_pkg::ADDR_W-1:0] wr_addr;
   fcls_pkg::log_entry_type     wr_entry;
   logic                        rd_en;
   logic [fcls_pkg::ADDR_W-1:0] rd_addr;
   fcls_pkg::log_entry_type     rd_entry;

   logic [fcls_pkg::SH_W-1:0] sh_addr;
   fcls_pkg::value_type       sh_rd;
   logic                      req_idx_ok;
   logic                      idx_ok;
   logic                      replay_more;

   // log page storage, one slot per entry
   fcls_log_ram #(
      .DEPTH (fcls_pkg::LOG_SLOTS),
      .WIDTH ($bits(fcls_pkg::log_entry_type))
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // single shadow read port
   assign sh_rd = shadow_ff[sh_addr];

   assign req_idx_ok  = {1'b0, req_data.setting_id} < fcls_pkg::SETTINGS_LIMIT;
   assign idx_ok      = {1'b0, idx_ff} < fcls_pkg::SETTINGS_LIMIT;
   assign replay_more = rd_cnt_ff < free_ff;

   // result fields
   always_comb begin
      res_data.status     = status_ff;
      res_data.read_value = idx_ok ? sh_rd : '0;
      res_data.slots_used = fcls_pkg::SLOTS_W'(free_ff);
   end

   // sequencer: next state, memory accesses, shadow updates
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      free_in   = free_ff;
      rd_cnt_in = rd_cnt_ff;
      rd_vld_in = 1'b0;
      shadow_in = shadow_ff;
      wr_en     = 1'b0;
      wr_addr   = free_ff[fcls_pkg::ADDR_W-1:0];
      wr_entry  = '0;
      rd_en     = 1'b0;
      rd_addr   = rd_cnt_ff[fcls_pkg::ADDR_W-1:0];
      sh_addr   = idx_ff[fcls_pkg::SH_W-1:0];
      req_ready = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         fcls_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in    = req_data.setting_id;
               status_in = fcls_pkg::STS_OK;
               state_in  = fcls_pkg::ST_DONE;
               priority if (req_data.command == fcls_pkg::CMD_LOAD) begin
                  // load restarts from the defaults
                  for (int k = 0; k < fcls_pkg::NUM_SETTINGS; k++) begin
                     shadow_in[k] = dflt[k];
                  end
                  if (free_ff == '0) begin
                     status_in = fcls_pkg::STS_DEFAULTS;
                     state_in  = fcls_pkg::ST_FILL;
                  end else begin
                     rd_cnt_in = '0;
                     state_in  = fcls_pkg::ST_REPLAY;
                  end
               end else if (!req_idx_ok) begin
                  status_in = fcls_pkg::STS_BAD_INDEX;
               end else if (req_data.command == fcls_pkg::CMD_SAVE) begin
                  shadow_in[req_data.setting_id[fcls_pkg::SH_W-1:0]] = req_data.write_value;
                  if (free_ff < fcls_pkg::PTR_FULL) begin
                     // append at the free slot
                     wr_en          = 1'b1;
                     wr_entry.index = req_data.setting_id;
                     wr_entry.value = req_data.write_value;
                     free_in        = free_ff + 1'b1;
                  end else begin
                     // page full: restart the page and rewrite the shadow
                     free_in   = '0;
                     status_in = fcls_pkg::STS_COMPACTED;
                     state_in  = fcls_pkg::ST_FILL;
                  end
               end else begin
                  status_in = fcls_pkg::STS_OK;
               end
            end
         end

         fcls_pkg::ST_FILL: begin
            // write one shadow value per cycle into the next slot
            sh_addr        = free_ff[fcls_pkg::SH_W-1:0];
            wr_en          = 1'b1;
            wr_entry.index = free_ff[fcls_pkg::IDX_W-1:0];
            wr_entry.value = sh_rd;
            free_in        = free_ff + 1'b1;
            if (free_ff == fcls_pkg::PTR_LAST_FILL) begin
               state_in = fcls_pkg::ST_DONE;
            end
         end

         fcls_pkg::ST_REPLAY: begin
            // issue one slot read per cycle, apply its data in the following cycle
            if (replay_more) begin
               rd_en     = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && ({1'b0, rd_entry.index} < fcls_pkg::SETTINGS_LIMIT)) begin
               shadow_in[rd_entry.index[fcls_pkg::SH_W-1:0]] = rd_entry.value;
            end
            if (!replay_more && !rd_vld_ff) begin
               state_in = fcls_pkg::ST_DONE;
            end
         end

         fcls_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = fcls_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fcls_pkg::ST_IDLE;
         free_ff   <= '0;
         rd_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         for (int k = 0; k < fcls_pkg::NUM_SETTINGS; k++) begin
            shadow_ff[k] <= fcls_pkg::reset_default(k);
         end
      end else begin
         state_ff  <= state_in;
         free_ff   <= free_in;
         rd_cnt_ff <= rd_cnt_in;
         rd_vld_ff <= rd_vld_in;
         shadow_ff <= shadow_in;
      end
   end

   // per-item payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

endmodule

`default_nettype wire

[hw/rtl/fcls_checker.sv]
`default_nettype none

`include "flash_config_log_store_defines.svh"

module fcls_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input fcls_pkg::rsp_type                rsp_data
);

   // a stalled result holds
   `FCLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one item in flight: no transfer right after a transfer
   `FCLS_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "input taken while busy")

   // a rewritten page holds exactly one slot per setting
   `FCLS_ASSERT(a_rewrite_count, rsp_valid && (rsp_data.status == fcls_pkg::STS_COMPACTED || rsp_data.status == fcls_pkg::STS_DEFAULTS) |-> rsp_data.slots_used == fcls_pkg::SLOTS_W'(fcls_pkg::NUM_SETTINGS), "wrong slot count after rewrite")

   // no result straight out of reset
   `FCLS_ASSERT(a_reset_empty, $fell(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind flash_config_log_store fcls_checker u_checker (.*);

`default_nettype wire
